// ----- src/mxst_pkg.sv -----
`timescale 1ns / 1ps

package mxst_pkg;

  localparam int unsigned KeyBitsDef  = 32;
  localparam int unsigned MaxItemsDef = 1024;

  typedef struct packed {
    logic [31:0] element;
    logic        restart;
  } in_req_t;

  typedef struct packed {
    logic [31:0] best_xor;
    logic [10:0] left_index;
    logic [10:0] right_index;
    logic        overflow;
  } out_rsp_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ZERO_START,
    CMD_INS_START,
    CMD_INS_STEP,
    CMD_INS_LEAF,
    CMD_Q_START,
    CMD_Q_STEP,
    CMD_FINISH,
    CMD_EMIT
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e op;
  } cmd_t;

  typedef struct packed {
    logic ovf;
    logic need_zero;
    logic last_level;
  } status_t;

endpackage

// ----- src/max_xor_subarray_trie.sv -----
`timescale 1ns / 1ps
// Maximum-XOR subarray finder over a binary trie of prefix XOR values.
// Input channel (in_valid_i/in_ready_o, in_req_i): one array element per
// request; restart set clears the trie and the running best first.
// Output channel (out_valid_o/out_ready_i, out_rsp_o): one result per
// request carrying the running best XOR and its one-based bounds; overflow
// marks an element past MAX_ITEMS that was dropped with state unchanged.
// A result follows the insert walk and the query walk, each stepping one
// trie level per cycle on the single-port node memory.
// The first request after reset or restart also inserts prefix zero first.
// An overflow request skips both walks and goes straight to the result.
// Throughput: one request at a time; in_ready_o is high only while idle.
// A finished result sits in the output register, so the next request is
// taken while it waits; a stalled receiver holds the block only when a
// second result is ready to be loaded.
// Reset: async, active low; trie empty, best undefined (reported as zero).
// Node memory needs no clearing pass; new nodes are written before use.
module max_xor_subarray_trie import mxst_pkg::*; #(
  parameter int unsigned KEY_BITS  = KeyBitsDef,
  parameter int unsigned MAX_ITEMS = MaxItemsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o
);

  cmd_t    cmd;
  status_t status;

  // Sequence the insert walk, query walk and result hand-off.
  mxst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold the trie memory, running prefix and best-so-far registers.
  mxst_datapath #(
    .KEY_BITS  (KEY_BITS),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_rsp_o (out_rsp_o)
  );

  // One request in flight: ready drops right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a second request while busy");

  // A real best always spans a nonempty, ordered range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (MAX_ITEMS <= 1024) && (out_rsp_o.right_index != 11'd0) |->
      (out_rsp_o.left_index != 11'd0) &&
      (out_rsp_o.left_index <= out_rsp_o.right_index))
    else $error("best subarray bounds out of order");

  // A new result shows up just as the controller returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result appeared outside the emit step");

endmodule

// ----- src/mxst_datapath.sv -----
`timescale 1ns / 1ps

module mxst_datapath import mxst_pkg::*; #(
  parameter int unsigned KEY_BITS  = KeyBitsDef,
  parameter int unsigned MAX_ITEMS = MaxItemsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_req_t  in_req_i,
  input  cmd_t     cmd_i,
  output status_t  status_o,
  output out_rsp_t out_rsp_o
);

  localparam int unsigned Nodes = KEY_BITS * (MAX_ITEMS + 1) + 1;
  localparam int unsigned NW    = $clog2(Nodes);
  localparam int unsigned IW    = $clog2(MAX_ITEMS + 1);
  localparam int unsigned LW    = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  typedef struct packed {
    logic [NW-1:0] c1;
    logic [NW-1:0] c0;
  } node_t;

  node_t mem_q [Nodes];

  logic [KEY_BITS-1:0] prefix_q, prefix_d;
  logic [IW-1:0]       item_q, item_d;
  logic [NW-1:0]       cnt_q, cnt_d;
  logic                need_zero_q, need_zero_d;
  logic                ovf_q, ovf_d;
  logic                best_vld_q, best_vld_d;
  logic [KEY_BITS-1:0] best_q, best_d;
  logic [IW-1:0]       best_l_q, best_l_d, best_r_q, best_r_d;
  logic [NW-1:0]       cur_q, cur_d;
  logic                fresh_q, fresh_d;
  logic [LW-1:0]       level_q, level_d;
  logic [KEY_BITS-1:0] wkey_q, wkey_d;
  logic [IW-1:0]       pos_q, pos_d;
  logic [KEY_BITS-1:0] qx_q, qx_d;
  node_t               rdata_q;
  out_rsp_t            out_q, out_d;

  logic          rd_en, wr_en;
  logic [NW-1:0] rd_addr, wr_addr;
  node_t         wr_data, entry;
  logic          bit_w;
  logic [NW-1:0] child, want_c, other_c;
  logic [IW-1:0] left;
  logic [KEY_BITS-1:0] elem;

  assign elem  = in_req_i.element[KEY_BITS-1:0];
  assign entry = fresh_q ? '0 : rdata_q;
  assign bit_w = wkey_q[KEY_BITS-1];
  assign child   = bit_w ? entry.c1 : entry.c0;
  assign want_c  = bit_w ? entry.c0 : entry.c1;
  assign other_c = bit_w ? entry.c1 : entry.c0;
  assign left    = rdata_q.c0[IW-1:0] + IW'(1);

  assign status_o.ovf        = ovf_q;
  assign status_o.need_zero  = need_zero_q;
  assign status_o.last_level = (level_q == LW'(KEY_BITS - 1));
  assign out_rsp_o           = out_q;

  always_comb begin
    prefix_d = prefix_q; item_d = item_q; cnt_d = cnt_q;
    need_zero_d = need_zero_q; ovf_d = ovf_q;
    best_vld_d = best_vld_q; best_d = best_q; best_l_d = best_l_q; best_r_d = best_r_q;
    cur_d = cur_q; fresh_d = fresh_q; level_d = level_q; wkey_d = wkey_q;
    pos_d = pos_q; qx_d = qx_q; out_d = out_q;
    rd_en = 1'b0; rd_addr = cur_q; wr_en = 1'b0; wr_addr = cur_q; wr_data = entry;
    unique case (cmd_i.op)
      CMD_LOAD: begin
        if (in_req_i.restart) begin
          ovf_d = 1'b0; prefix_d = elem; item_d = IW'(1); cnt_d = NW'(1);
          need_zero_d = 1'b1; best_vld_d = 1'b0; best_l_d = '0; best_r_d = '0;
        end else if (item_q == IW'(MAX_ITEMS)) begin
          ovf_d = 1'b1;
        end else begin
          ovf_d = 1'b0; prefix_d = prefix_q ^ elem; item_d = item_q + IW'(1);
        end
      end
      CMD_ZERO_START: begin
        cur_d = '0; fresh_d = 1'b1; level_d = '0; wkey_d = '0; pos_d = '0;
      end
      CMD_INS_START: begin
        cur_d = '0; fresh_d = 1'b0; level_d = '0; wkey_d = prefix_q; pos_d = item_q;
        rd_en = 1'b1; rd_addr = '0;
      end
      CMD_INS_STEP: begin
        level_d = level_q + LW'(1);
        wkey_d  = wkey_q << 1;
        if (child != '0) begin
          rd_en = 1'b1; rd_addr = child; cur_d = child; fresh_d = 1'b0;
        end else begin
          wr_en = 1'b1; wr_data = entry;
          if (bit_w) wr_data.c1 = cnt_q;
          else       wr_data.c0 = cnt_q;
          cur_d = cnt_q; fresh_d = 1'b1; cnt_d = cnt_q + NW'(1);
        end
      end
      CMD_INS_LEAF: begin
        // A new leaf records where its prefix first appeared.
        if (fresh_q) begin
          wr_en = 1'b1; wr_data.c1 = '0; wr_data.c0 = NW'(pos_q);
        end
        need_zero_d = 1'b0;
      end
      CMD_Q_START: begin
        cur_d = '0; fresh_d = 1'b0; level_d = '0; wkey_d = prefix_q; qx_d = '0;
        rd_en = 1'b1; rd_addr = '0;
      end
      CMD_Q_STEP: begin
        level_d = level_q + LW'(1);
        wkey_d  = wkey_q << 1;
        rd_en   = 1'b1;
        if (want_c != '0) begin
          rd_addr = want_c;
          qx_d = (qx_q << 1) | KEY_BITS'(1);
        end else begin
          rd_addr = other_c; qx_d = qx_q << 1;
        end
      end
      CMD_FINISH: begin
        if (!best_vld_q || qx_q > best_q) begin
          best_vld_d = 1'b1; best_d = qx_q; best_l_d = left; best_r_d = item_q;
        end else if (qx_q == best_q && left < best_l_q) begin
          best_l_d = left; best_r_d = item_q;
        end
      end
      CMD_EMIT: begin
        out_d.overflow = ovf_q;
        if (best_vld_q) begin
          out_d.best_xor    = 32'(best_q);
          out_d.left_index  = 11'({11'b0, best_l_q});
          out_d.right_index = 11'({11'b0, best_r_q});
        end else begin
          out_d.best_xor = '0; out_d.left_index = '0; out_d.right_index = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= '0; item_q <= '0; cnt_q <= NW'(1); need_zero_q <= 1'b1; ovf_q <= 1'b0;
      best_vld_q <= 1'b0; best_l_q <= '0; best_r_q <= '0;
      level_q <= '0; fresh_q <= 1'b0; cur_q <= '0;
    end else begin
      prefix_q <= prefix_d; item_q <= item_d; cnt_q <= cnt_d; need_zero_q <= need_zero_d;
      ovf_q <= ovf_d; best_vld_q <= best_vld_d; best_l_q <= best_l_d; best_r_q <= best_r_d;
      level_q <= level_d; fresh_q <= fresh_d; cur_q <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d; wkey_q <= wkey_d; pos_q <= pos_d; qx_q <= qx_d; out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

endmodule

// ----- src/mxst_ctrl.sv -----
`timescale 1ns / 1ps

module mxst_ctrl import mxst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_START   = 8'b0000_0010,
    ST_INS     = 8'b0000_0100,
    ST_INS_LF  = 8'b0000_1000,
    ST_Q_START = 8'b0001_0000,
    ST_Q       = 8'b0010_0000,
    ST_FINISH  = 8'b0100_0000,
    ST_EMIT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = CMD_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        cmd_o.op = CMD_LOAD; state_d = ST_START;
      end
      ST_START: begin
        if (status_i.ovf) begin
          state_d = ST_EMIT;
        end else if (status_i.need_zero) begin
          cmd_o.op = CMD_ZERO_START; state_d = ST_INS;
        end else begin
          cmd_o.op = CMD_INS_START; state_d = ST_INS;
        end
      end
      ST_INS: begin
        cmd_o.op = CMD_INS_STEP;
        if (status_i.last_level) state_d = ST_INS_LF;
      end
      ST_INS_LF: begin
        cmd_o.op = CMD_INS_LEAF;
        state_d  = status_i.need_zero ? ST_START : ST_Q_START;
      end
      ST_Q_START: begin
        cmd_o.op = CMD_Q_START; state_d = ST_Q;
      end
      ST_Q: begin
        cmd_o.op = CMD_Q_STEP;
        if (status_i.last_level) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.op = CMD_FINISH; state_d = ST_EMIT;
      end
      ST_EMIT: if (!out_valid_q || out_ready_i) begin
        cmd_o.op = CMD_EMIT; out_valid_d = 1'b1; state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- verif/mxst_checker.sv -----
`timescale 1ns / 1ps
module mxst_checker import mxst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  in_req_t  in_req_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  out_rsp_t out_rsp_i,
  output int       fail_count_o,
  output int       pending_o
);

  localparam int unsigned MaxItems = MaxItemsDef;

  // distinct prefixes seen in the current array, with first positions
  logic [31:0] prefix_key[$];
  logic [10:0] prefix_pos[$];
  logic [31:0] run_xor;
  int unsigned taken;
  longint      best_val;
  logic [10:0] best_lo;
  logic [10:0] best_hi;
  out_rsp_t    expected_rsp[$];
  int          fail_cnt = 0;

  function automatic void clear_array();
    prefix_key = '{32'd0};
    prefix_pos = '{11'd0};
    run_xor = '0;
    taken = 0;
    best_val = -1;
    best_lo = '0;
    best_hi = '0;
  endfunction

  function automatic out_rsp_t predict_best(in_req_t req);
    out_rsp_t    rsp;
    bit          found;
    logic [31:0] top_x;
    logic [31:0] v;
    logic [10:0] top_pos;
    logic [10:0] lo;
    found = 0;
    top_x = '0;
    top_pos = '0;
    rsp = '0;
    if (req.restart) clear_array();
    if (taken >= MaxItems) begin
      rsp.overflow = 1'b1;
    end else begin
      taken++;
      run_xor ^= req.element;
      foreach (prefix_key[k]) if (prefix_key[k] == run_xor) found = 1;
      if (!found) begin
        prefix_key.push_back(run_xor);
        prefix_pos.push_back(11'(taken));
      end
      foreach (prefix_key[k]) begin
        v = prefix_key[k] ^ run_xor;
        if (k == 0 || v > top_x) begin
          top_x = v;
          top_pos = prefix_pos[k];
        end
      end
      lo = top_pos + 11'd1;
      if (longint'(top_x) > best_val) begin
        best_val = top_x;
        best_lo = lo;
        best_hi = 11'(taken);
      end else if (longint'(top_x) == best_val && lo < best_lo) begin
        best_lo = lo;
        best_hi = 11'(taken);
      end
    end
    if (best_val >= 0) begin
      rsp.best_xor = best_val[31:0];
      rsp.left_index = best_lo;
      rsp.right_index = best_hi;
    end
    return rsp;
  endfunction

  assign pending_o = expected_rsp.size();
  assign fail_count_o = fail_cnt;

  always @(posedge clk_i) begin
    out_rsp_t want;
    if (!rst_ni) begin
      clear_array();
    end else begin
      if (in_valid_i && in_ready_i) expected_rsp.push_back(predict_best(in_req_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("unexpected result %p", out_rsp_i);
        end else begin
          want = expected_rsp.pop_front();
          if (want !== out_rsp_i) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: expected %p actual %p", want, out_rsp_i);
          end
        end
      end
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import mxst_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  out_rsp_t out_rsp_o;
  int       fail_count;
  int       pending;
  bit       sink_quiet = 0;  // last stretch: receiver never idles
  bit       long_hold = 0;   // request a long receiver hold-off
  bit       hold_done = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  max_xor_subarray_trie dut (.*);

  mxst_checker u_check (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_req_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_rsp_i(out_rsp_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Offer one request, hold it until accepted, then maybe idle a burst.
  task automatic send_req(logic [31:0] elem, logic rs, bit may_idle);
    int gap;
    in_valid_i <= 1'b1;
    in_req_i <= '{element: elem, restart: rs};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Random element: biased toward small values and values near all ones.
  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFFF ^ $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (long_hold && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_done = 1;
      end else if (!sink_quiet && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 11);
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: extremes, repeats, zero element, restart.
    send_req(32'h0, 1'b0, 0);
    send_req(32'hFFFF_FFFF, 1'b0, 0);
    send_req(32'hFFFF_FFFF, 1'b0, 0);
    send_req(32'h8000_0000, 1'b0, 1);
    send_req(32'h0000_0001, 1'b0, 1);
    send_req(32'h5555_5555, 1'b0, 0);
    send_req(32'hAAAA_AAAA, 1'b0, 0);
    send_req(32'h0, 1'b1, 0);
    send_req(32'h7, 1'b1, 0);
    send_req(32'h7, 1'b0, 0);
    send_req(32'h3, 1'b0, 0);
    // Fill past capacity to hit overflow, with long receiver hold-off.
    long_hold = 1;
    send_req(32'h1234_5678, 1'b1, 0);
    for (n = 1; n < 1024 - 300; n++) send_req(rand_elem(), 1'b0, n > 400);
    // Pause until all results are in.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    for (n = 0; n < 300; n++) send_req(rand_elem(), 1'b0, 1);
    send_req(32'hDEAD_BEEF, 1'b0, 0);
    send_req(32'h0, 1'b0, 0);
    // Short arrays with frequent restarts; quiet at the end.
    for (n = 0; n < 12; n++) begin
      if (n > 8) sink_quiet = 1;
      send_req(rand_elem(), $urandom_range(0, 3) == 0, n <= 8);
    end
    send_req(32'hFFFF_FFFF, 1'b1, 0);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #30ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- max_xor_subarray_trie.f -----
src/mxst_pkg.sv
src/mxst_datapath.sv
src/mxst_ctrl.sv
src/max_xor_subarray_trie.sv
verif/mxst_checker.sv
verif/tb_top.sv
